[src/flash_write_combine_cache_defines.svh]
// Assertion macros shared by the flash write-combining cache modules.
`ifndef FLASH_WRITE_COMBINE_CACHE_DEFINES_SVH
`define FLASH_WRITE_COMBINE_CACHE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FWCC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define FWCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/fwcc_pkg.sv]
// Types, constants and codes shared by the flash write-combining cache modules.
package fwcc_pkg;

    localparam int LINE_WORDS = 8;
    localparam int IDX_W      = $clog2(LINE_WORDS);
    localparam int OFF_W      = IDX_W + 2;
    localparam int MEM_AW     = IDX_W + 1;
    localparam int MEM_DEPTH  = 2 * LINE_WORDS;

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(LINE_WORDS - 1);
    localparam logic [31:0]      ALL_ONES  = 32'hffff_ffff;
    localparam logic [31:0]      IMG_RESET = 32'd134234112;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_RESET = 2'd2;

    localparam logic [1:0] KIND_FLUSH = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RD_WAIT,
        S_STREAM_RD,
        S_STREAM_OUT,
        S_POST,
        S_RESP
    } t_state;

    typedef struct packed {
        logic capture;
        logic cache_reset;
        logic write_commit;
        logic rd_req;
        logic rd_stream;
        logic latch_rv;
        logic invert_rv;
        logic cnt_clr;
        logic cnt_inc;
        logic sel_set;
        logic sel_val;
        logic clear0;
        logic clear1;
        logic load_flush;
        logic load_resp;
        logic resp_failed;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       flush_wr;
        logic       flush_rd;
        logic       dirty1;
        logic       ok0;
        logic       ok1;
        logic       sel;
        logic       cnt_last;
        logic       out_free;
    } t_dp_status;

endpackage

[src/fwcc_dp.sv]
// Datapath of the flash write-combining cache: request, tags, line memory, output register.
`include "flash_write_combine_cache_defines.svh"

module fwcc_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fwcc_pkg::t_dp_cmd    i_cmd,
    output fwcc_pkg::t_dp_status o_status,
    input  logic [1:0]           i_mode,
    input  logic [31:0]          i_address,
    input  logic [31:0]          i_write_data,
    input  logic [31:0]          i_flash_data,
    input  logic                 i_second_line_program_ok,
    input  logic                 i_first_line_program_ok,
    input  logic                 i_cfg_wr_en,
    input  logic [31:0]          i_cfg_wr_data,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic [1:0]           o_kind,
    output logic [31:0]          o_target_address,
    output logic [31:0]          o_data,
    output logic                 o_failed,
    output logic                 o_last
);

    logic [31:0] r_cfg;
    logic [1:0]  r_mode;
    logic [31:0] r_addr;
    logic [31:0] r_wdata;
    logic [31:0] r_fdata;
    logic        r_ok0;
    logic        r_ok1;

    logic [1:0][31:0]                   r_tag;
    logic [1:0]                         r_dirty;
    logic [1:0][fwcc_pkg::IDX_W-1:0]    r_last_idx;
    logic [31:0]                        r_mem [fwcc_pkg::MEM_DEPTH];
    logic [fwcc_pkg::MEM_DEPTH-1:0]     r_valid;
    logic [31:0]                        r_mem_q;
    logic                               r_q_valid;
    logic [31:0]                        r_rv;
    logic [fwcc_pkg::IDX_W-1:0]         r_cnt;
    logic                               r_sel;

    logic        r_out_valid;
    logic [1:0]  r_out_kind;
    logic [31:0] r_out_addr;
    logic [31:0] r_out_data;
    logic        r_out_failed;
    logic        r_out_last;

    logic [fwcc_pkg::IDX_W-1:0]  req_idx;
    logic [31:0]                 req_base;
    logic                        hit0;
    logic                        hit1;
    logic                        claim;
    logic                        wr_en;
    logic [fwcc_pkg::MEM_AW-1:0] wr_addr;
    logic                        rd_en;
    logic [fwcc_pkg::MEM_AW-1:0] rd_addr;
    logic [31:0]                 word_q;
    logic [31:0]                 stream_addr;
    logic                        out_free;

    assign req_idx  = r_addr[fwcc_pkg::OFF_W-1:2];
    assign req_base = {r_addr[31:fwcc_pkg::OFF_W], {fwcc_pkg::OFF_W{1'b0}}};
    assign hit0     = (r_tag[0] == req_base);
    assign hit1     = !hit0 && (r_tag[1] == req_base);
    assign claim    = !hit0 && !hit1 && (req_idx == '0);
    assign wr_en    = i_cmd.write_commit && (hit0 || hit1 || claim);
    assign wr_addr  = {!hit0, req_idx};
    assign rd_en    = i_cmd.rd_req || i_cmd.rd_stream;
    assign rd_addr  = i_cmd.rd_stream ? {r_sel, r_cnt} : {!hit0, req_idx};
    assign word_q   = r_q_valid ? r_mem_q : fwcc_pkg::ALL_ONES;
    assign stream_addr = r_tag[r_sel] + {{(32 - fwcc_pkg::OFF_W){1'b0}}, r_cnt, 2'b00};
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_status          = '0;
        o_status.mode     = r_mode;
        o_status.flush_wr = hit0 && (req_idx == '0) && r_dirty[0]
                            && (r_last_idx[0] == fwcc_pkg::LAST_IDX);
        o_status.flush_rd = hit1 && (req_idx == fwcc_pkg::LAST_IDX);
        o_status.dirty1   = r_dirty[1];
        o_status.ok0      = r_ok0;
        o_status.ok1      = r_ok1;
        o_status.sel      = r_sel;
        o_status.cnt_last = (r_cnt == fwcc_pkg::LAST_IDX);
        o_status.out_free = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= fwcc_pkg::IMG_RESET;
        end else if (i_cfg_wr_en) begin
            r_cfg <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode  <= i_mode;
            r_addr  <= i_address;
            r_wdata <= i_write_data;
            r_fdata <= i_flash_data;
            r_ok0   <= i_first_line_program_ok;
            r_ok1   <= i_second_line_program_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag[0] <= fwcc_pkg::IMG_RESET;
            r_tag[1] <= fwcc_pkg::ALL_ONES;
            r_dirty  <= '0;
            r_valid  <= '0;
        end else begin
            if (i_cmd.cache_reset) begin
                r_tag[0] <= r_cfg;
                r_tag[1] <= fwcc_pkg::ALL_ONES;
                r_dirty  <= '0;
                r_valid  <= '0;
            end
            if (i_cmd.clear0) begin
                r_tag[0]   <= fwcc_pkg::ALL_ONES;
                r_dirty[0] <= 1'b0;
                for (int i = 0; i < fwcc_pkg::LINE_WORDS; i++) begin
                    r_valid[i] <= 1'b0;
                end
            end
            if (i_cmd.clear1) begin
                r_tag[1]   <= fwcc_pkg::ALL_ONES;
                r_dirty[1] <= 1'b0;
                for (int i = 0; i < fwcc_pkg::LINE_WORDS; i++) begin
                    r_valid[fwcc_pkg::LINE_WORDS + i] <= 1'b0;
                end
            end
            if (i_cmd.write_commit && claim) begin
                r_tag[1] <= r_addr;
            end
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
                if (!o_status.flush_wr) begin
                    r_dirty[!hit0] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && !o_status.flush_wr) begin
            r_last_idx[!hit0] <= req_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_wdata;
        end
        if (rd_en) begin
            r_mem_q   <= r_mem[rd_addr];
            r_q_valid <= r_valid[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_rv) begin
            r_rv <= (hit0 || hit1) ? word_q : r_fdata;
        end else if (i_cmd.invert_rv) begin
            r_rv <= ~r_rv;
        end
        if (i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.sel_set) begin
            r_sel <= i_cmd.sel_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_flush || i_cmd.load_resp) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_flush) begin
            r_out_kind   <= fwcc_pkg::KIND_FLUSH;
            r_out_addr   <= stream_addr;
            r_out_data   <= word_q;
            r_out_failed <= 1'b0;
            r_out_last   <= 1'b0;
        end else if (i_cmd.load_resp) begin
            r_out_kind   <= (r_mode == fwcc_pkg::MODE_READ) ? fwcc_pkg::KIND_READ
                                                            : fwcc_pkg::KIND_DONE;
            r_out_addr   <= r_addr;
            r_out_data   <= (r_mode == fwcc_pkg::MODE_READ) ? r_rv : 32'd0;
            r_out_failed <= i_cmd.resp_failed;
            r_out_last   <= 1'b1;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_out_kind;
    assign o_target_address = r_out_addr;
    assign o_data           = r_out_data;
    assign o_failed         = r_out_failed;
    assign o_last           = r_out_last;

    `FWCC_ASSERT_IMPL(a_load_needs_room, i_cmd.load_flush || i_cmd.load_resp, out_free, "result loaded over a pending one")
    `FWCC_ASSERT_IMPL(a_dirty0_tagged, r_dirty[0], r_tag[0] != fwcc_pkg::ALL_ONES, "dirty line zero has no tag")
    `FWCC_ASSERT_IMPL(a_dirty1_tagged, r_dirty[1], r_tag[1] != fwcc_pkg::ALL_ONES, "dirty line one has no tag")

endmodule

[src/fwcc_ctrl.sv]
// Controller state machine of the flash write-combining cache.
`include "flash_write_combine_cache_defines.svh"

module fwcc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  fwcc_pkg::t_dp_status i_status,
    output fwcc_pkg::t_dp_cmd    o_cmd
);

    fwcc_pkg::t_state r_state;
    fwcc_pkg::t_state n_state;
    logic             r_failed;
    logic             n_failed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= fwcc_pkg::S_IDLE;
            r_failed <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_failed <= n_failed;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            fwcc_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = fwcc_pkg::S_DECODE;
                end
            end
            fwcc_pkg::S_DECODE: begin
                if (i_status.mode == fwcc_pkg::MODE_WRITE) begin
                    n_state = i_status.flush_wr ? fwcc_pkg::S_STREAM_RD : fwcc_pkg::S_RESP;
                end else if (i_status.mode == fwcc_pkg::MODE_READ) begin
                    n_state = fwcc_pkg::S_RD_WAIT;
                end else begin
                    n_state = fwcc_pkg::S_IDLE;
                end
            end
            fwcc_pkg::S_RD_WAIT: begin
                n_state = i_status.flush_rd ? fwcc_pkg::S_STREAM_RD : fwcc_pkg::S_RESP;
            end
            fwcc_pkg::S_STREAM_RD: begin
                n_state = fwcc_pkg::S_STREAM_OUT;
            end
            fwcc_pkg::S_STREAM_OUT: begin
                if (i_status.out_free) begin
                    n_state = i_status.cnt_last ? fwcc_pkg::S_POST : fwcc_pkg::S_STREAM_RD;
                end
            end
            fwcc_pkg::S_POST: begin
                if (i_status.mode == fwcc_pkg::MODE_WRITE && i_status.sel && i_status.ok1) begin
                    n_state = fwcc_pkg::S_STREAM_RD;
                end else begin
                    n_state = fwcc_pkg::S_RESP;
                end
            end
            fwcc_pkg::S_RESP: begin
                if (i_status.out_free) begin
                    n_state = fwcc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fwcc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        n_failed   = r_failed;
        o_in_stall = (r_state != fwcc_pkg::S_IDLE) || !i_rst_n;
        case (r_state)
            fwcc_pkg::S_IDLE: begin
                o_cmd.capture = i_in_valid && i_rst_n;
            end
            fwcc_pkg::S_DECODE: begin
                n_failed = 1'b0;
                if (i_status.mode == fwcc_pkg::MODE_WRITE) begin
                    o_cmd.write_commit = 1'b1;
                    if (i_status.flush_wr) begin
                        o_cmd.cnt_clr = 1'b1;
                        o_cmd.sel_set = 1'b1;
                        o_cmd.sel_val = i_status.dirty1;
                    end
                end else if (i_status.mode == fwcc_pkg::MODE_READ) begin
                    o_cmd.rd_req = 1'b1;
                end else if (i_status.mode == fwcc_pkg::MODE_RESET) begin
                    o_cmd.cache_reset = 1'b1;
                end
            end
            fwcc_pkg::S_RD_WAIT: begin
                o_cmd.latch_rv = 1'b1;
                if (i_status.flush_rd) begin
                    o_cmd.cnt_clr = 1'b1;
                    o_cmd.sel_set = 1'b1;
                    o_cmd.sel_val = 1'b1;
                end
            end
            fwcc_pkg::S_STREAM_RD: begin
                o_cmd.rd_stream = 1'b1;
            end
            fwcc_pkg::S_STREAM_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.load_flush = 1'b1;
                    o_cmd.cnt_inc    = 1'b1;
                end
            end
            fwcc_pkg::S_POST: begin
                if (i_status.mode == fwcc_pkg::MODE_READ) begin
                    o_cmd.clear1    = i_status.ok1;
                    o_cmd.invert_rv = !i_status.ok1;
                end else if (i_status.sel) begin
                    if (i_status.ok1) begin
                        o_cmd.cnt_clr = 1'b1;
                        o_cmd.sel_set = 1'b1;
                        o_cmd.sel_val = 1'b0;
                    end else begin
                        o_cmd.clear1 = 1'b1;
                        n_failed     = 1'b1;
                    end
                end else begin
                    o_cmd.clear0 = 1'b1;
                    n_failed     = !i_status.ok0;
                end
            end
            fwcc_pkg::S_RESP: begin
                if (i_status.out_free) begin
                    o_cmd.load_resp   = 1'b1;
                    o_cmd.resp_failed = r_failed;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    `FWCC_ASSERT_NEXT(a_stream_ends, r_state == fwcc_pkg::S_STREAM_OUT && i_status.out_free && i_status.cnt_last, r_state == fwcc_pkg::S_POST, "line stream did not end after its last word")
    `FWCC_ASSERT_NEXT(a_resp_to_idle, r_state == fwcc_pkg::S_RESP && i_status.out_free, r_state == fwcc_pkg::S_IDLE && $past(o_cmd.load_resp), "response not issued before returning to idle")

endmodule

[src/flash_write_combine_cache.sv]
// Top level of the two-line write-combining cache in front of flash programming.
//
// Channel   Direction  Handshake               Payload
// request   in         i_in_valid/o_in_stall   mode, address, write_data, flash_data, ok bits
// result    out        o_out_valid/i_out_stall kind, target_address, data, failed, last
// config    in         i_cfg_wr_en             i_cfg_wr_data (image start address)
//
// One request is handled at a time.
// Each flushed word is read from the line memory before it is loaded into the output register,
// because the line memory has a single registered read port. A write can flush both lines.
// Reset is synchronous and active low; no clearing pass is needed afterward.
// A stalled result holds the output register, and the controller waits on it.

module flash_write_combine_cache (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_address,
    input  logic [31:0] i_write_data,
    input  logic [31:0] i_flash_data,
    input  logic        i_second_line_program_ok,
    input  logic        i_first_line_program_ok,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [31:0] o_target_address,
    output logic [31:0] o_data,
    output logic        o_failed,
    output logic        o_last
);

    fwcc_pkg::t_dp_cmd    cmd;
    fwcc_pkg::t_dp_status status;

    fwcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    fwcc_dp u_dp (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_cmd                    (cmd),
        .o_status                 (status),
        .i_mode                   (i_mode),
        .i_address                (i_address),
        .i_write_data             (i_write_data),
        .i_flash_data             (i_flash_data),
        .i_second_line_program_ok (i_second_line_program_ok),
        .i_first_line_program_ok  (i_first_line_program_ok),
        .i_cfg_wr_en              (i_cfg_wr_en),
        .i_cfg_wr_data            (i_cfg_wr_data),
        .i_out_stall              (i_out_stall),
        .o_out_valid              (o_out_valid),
        .o_kind                   (o_kind),
        .o_target_address         (o_target_address),
        .o_data                   (o_data),
        .o_failed                 (o_failed),
        .o_last                   (o_last)
    );

endmodule
